/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the verification files of the ramp block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lpr_pkg.sv */
// Package with the action codes of the parameter ramp block.
`timescale 1ns / 1ps

package lpr_pkg;

  // Action carried by an input transaction; the fourth code only reports state.
  typedef enum logic [1:0] {
    ACT_RESET    = 2'd0,
    ACT_SET_GOAL = 2'd1,
    ACT_ADVANCE  = 2'd2
  } act_t;

  localparam int ACT_W = 2;

endpackage

/* hw/rtl/lpr_ifs.sv */
// Valid/ready channel interfaces for the ramp input and result transactions.
`timescale 1ns / 1ps

interface lpr_in_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic [lpr_pkg::ACT_W-1:0]     action;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [COUNT_WIDTH-1:0]        sample_count;

  modport source (output valid, output action, output value, output sample_count,
                  input ready);
  modport sink   (input valid, input action, input value, input sample_count,
                  output ready);
endinterface

interface lpr_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] current_level;
  logic signed [VALUE_WIDTH-1:0] goal_level;
  logic                          ramping;

  modport source (output valid, output current_level, output goal_level,
                  output ramping, input ready);
  modport sink   (input valid, input current_level, input goal_level,
                  input ramping, output ready);
endinterface

/* hw/rtl/linear_parameter_ramp.sv */
// Top level of the linear parameter ramp smoother.
//
//   Channel  Direction  Carries
//   in_ch    sink       action, value, sample_count
//   out_ch   source     current_level, goal_level, ramping
//
// Reset, set-goal, a no-op advance and an advance that ends the ramp update
// the state on accept and then load the result.
// An advance inside the ramp is accepted, runs the bit-serial multiplier, is
// handed off to the restoring divider, is written back and then loads the
// result; the multiplier and the divider each work one bit per cycle.
// rst_n is synchronous and active low and clears all levels and the count.
// A new transaction is taken while the previous result waits in the output
// register; a result that cannot be loaded holds the block until out_ch.ready.
`timescale 1ns / 1ps

module linear_parameter_ramp #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  lpr_in_if.sink    in_ch,
  lpr_out_if.source out_ch
);

  import lpr_pkg::*;

  // The level difference needs one extra bit; its magnitude fits the same width.
  localparam int MAG_W  = VALUE_WIDTH + 1;
  localparam int PROD_W = MAG_W + COUNT_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] level_now_r, level_now_nxt;
  logic [VALUE_WIDTH-1:0] level_goal_r, level_goal_nxt;
  logic [COUNT_WIDTH-1:0] samples_left_r, samples_left_nxt;
  logic [COUNT_WIDTH-1:0] consumed_r, consumed_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_cur_r, out_cur_nxt;
  logic [VALUE_WIDTH-1:0] out_goal_r, out_goal_nxt;
  logic                   out_ramp_r, out_ramp_nxt;

  logic                   accept;
  logic [MAG_W-1:0]       delta;
  logic                   delta_neg;
  logic [MAG_W-1:0]       mag;
  logic                   mul_start;
  logic                   mul_done;
  logic [PROD_W-1:0]      prod;
  logic                   div_done;
  logic [MAG_W-1:0]       quot;
  logic [MAG_W-1:0]       step;
  logic [VALUE_WIDTH-1:0] level_stepped;
  logic                   out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Signed gap from the current level to the goal, and its magnitude.
  assign delta     = {level_goal_r[VALUE_WIDTH-1], level_goal_r}
                   - {level_now_r[VALUE_WIDTH-1], level_now_r};
  assign delta_neg = delta[MAG_W-1];
  assign mag       = delta_neg ? (MAG_W'(0) - delta) : delta;

  // Only an advance that stays inside the ramp needs the serial arithmetic.
  assign mul_start = accept && (in_ch.action == ACT_ADVANCE)
                   && (samples_left_r != '0) && (in_ch.sample_count < samples_left_r);

  lpr_mul #(
    .MAG_W (MAG_W),
    .CNT_W (COUNT_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mag   (mag),
    .num   (in_ch.sample_count),
    .done  (mul_done),
    .prod  (prod)
  );

  // The divisor is the remaining count, which holds still until the step lands.
  lpr_div #(
    .MAG_W (MAG_W),
    .CNT_W (COUNT_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_done),
    .prod  (prod),
    .den   (samples_left_r),
    .done  (div_done),
    .quot  (quot)
  );

  // The quotient is truncated toward zero, so the sign is applied afterward.
  assign step          = neg_r ? (MAG_W'(0) - quot) : quot;
  assign level_stepped = level_now_r + step[VALUE_WIDTH-1:0];

  always_comb begin
    state_nxt        = state_r;
    level_now_nxt    = level_now_r;
    level_goal_nxt   = level_goal_r;
    samples_left_nxt = samples_left_r;
    consumed_nxt     = consumed_r;
    neg_nxt          = neg_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_cur_nxt      = out_cur_r;
    out_goal_nxt     = out_goal_r;
    out_ramp_nxt     = out_ramp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EMIT;
          unique case (in_ch.action)
            ACT_RESET: begin
              level_now_nxt    = in_ch.value;
              level_goal_nxt   = in_ch.value;
              samples_left_nxt = '0;
            end
            ACT_SET_GOAL: begin
              level_goal_nxt = in_ch.value;
              if (in_ch.sample_count == '0) begin
                level_now_nxt    = in_ch.value;
                samples_left_nxt = '0;
              end else begin
                samples_left_nxt = in_ch.sample_count;
              end
            end
            ACT_ADVANCE: begin
              if (samples_left_r == '0) begin
                // No ramp pending: the state is only reported.
              end else if (in_ch.sample_count >= samples_left_r) begin
                level_now_nxt    = level_goal_r;
                samples_left_nxt = '0;
              end else begin
                consumed_nxt = in_ch.sample_count;
                neg_nxt      = delta_neg;
                state_nxt    = ST_MUL;
              end
            end
            default: begin
              // The unused action code leaves the state alone.
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          level_now_nxt    = level_stepped;
          samples_left_nxt = samples_left_r - consumed_r;
          state_nxt        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = level_now_r;
          out_goal_nxt  = level_goal_r;
          out_ramp_nxt  = (samples_left_r != '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      level_now_r    <= '0;
      level_goal_r   <= '0;
      samples_left_r <= '0;
      consumed_r     <= '0;
      neg_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      out_cur_r      <= '0;
      out_goal_r     <= '0;
      out_ramp_r     <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      level_now_r    <= level_now_nxt;
      level_goal_r   <= level_goal_nxt;
      samples_left_r <= samples_left_nxt;
      consumed_r     <= consumed_nxt;
      neg_r          <= neg_nxt;
      out_valid_r    <= out_valid_nxt;
      out_cur_r      <= out_cur_nxt;
      out_goal_r     <= out_goal_nxt;
      out_ramp_r     <= out_ramp_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.current_level = out_cur_r;
  assign out_ch.goal_level    = out_goal_r;
  assign out_ch.ramping       = out_ramp_r;

endmodule

/* hw/rtl/lpr_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module lpr_mul #(
  parameter int MAG_W = 33,
  parameter int CNT_W = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [MAG_W-1:0]       mag,
  input  logic [CNT_W-1:0]       num,
  output logic                   done,
  output logic [MAG_W+CNT_W-1:0] prod
);

  localparam int PROD_W = MAG_W + CNT_W;
  localparam int STEP_W = $clog2(CNT_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [CNT_W-1:0]  num_r, num_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    num_nxt  = num_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(CNT_W);
      mag_nxt  = mag;
      num_nxt  = num;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // Double the partial product and add the magnitude for a set bit.
      acc_nxt = {acc_r[PROD_W-2:0], 1'b0} + (num_r[CNT_W-1] ? PROD_W'(mag_r) : '0);
      num_nxt = {num_r[CNT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    num_r <= num_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* hw/rtl/lpr_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module lpr_div #(
  parameter int MAG_W = 33,
  parameter int CNT_W = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [MAG_W+CNT_W-1:0] prod,
  input  logic [CNT_W-1:0]       den,
  output logic                   done,
  output logic [MAG_W-1:0]       quot
);

  localparam int PROD_W = MAG_W + CNT_W;
  localparam int STEP_W = $clog2(MAG_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  qs_r, qs_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // The dividend bits shift out of qs_r while the quotient bits shift in.
  assign trial = {rem_r, qs_r[MAG_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    qs_nxt   = qs_r;
    if (start) begin
      // The upper product bits are already below the divisor.
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(MAG_W);
      rem_nxt  = prod[PROD_W-1 -: CNT_W];
      qs_nxt   = prod[MAG_W-1:0];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      qs_nxt  = {qs_r[MAG_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    qs_r  <= qs_nxt;
  end

  assign done = done_r;
  assign quot = qs_r;

endmodule

/* hw/rtl/lpr_chk.sv */
// Port-level checker for the ramp block and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_chk #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_current,
  input logic [VALUE_WIDTH-1:0] out_goal,
  input logic                   out_ramping
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // A result that is not taken stays offered.
  `LPR_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_stall, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `LPR_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_stall, $stable(out_current) && $stable(out_goal) && $stable(out_ramping), "result payload changed while stalled")

  // The block works on one transaction at a time.
  `LPR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !in_ready, "input taken while busy")

  // With no ramp pending the current level sits on the goal.
  `LPR_ASSERT_NOW(a_idle_on_goal, clk, rst_n, out_valid && !out_ramping, out_current == out_goal, "level off goal with no ramp")

  // The cycle after a reset cycle offers no result.
  `LPR_ASSERT_NEXT(a_no_result_after_reset, clk, 1'b1, !rst_n, !out_valid, "result shown right after reset")

endmodule

bind linear_parameter_ramp lpr_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_lpr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_current (out_ch.current_level),
  .out_goal    (out_ch.goal_level),
  .out_ramping (out_ch.ramping)
);

/* tb/linear_parameter_ramp_tb.sv */
// Self-checking testbench for the linear parameter ramp smoother.
`timescale 1ns / 1ps

module linear_parameter_ramp_tb;
  import lpr_pkg::*;

  localparam int VW = 32;
  localparam int CW = 24;

  // The fourth action code has no enum member; the block only reports its state for it.
  localparam logic [ACT_W-1:0] ACT_REPORT_ONLY = 2'd3;

  localparam logic signed [VW-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] LEVEL_MIN = 32'sh8000_0000;
  localparam logic [CW-1:0]        SPAN_MAX  = 24'hFF_FFFF;

  // A slow but correct run, with its serial advances and the longest gaps on both
  // sides, stays well below this limit, so this only trips on a hang.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 800;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic signed [VW-1:0] current_level;
    logic signed [VW-1:0] goal_level;
    logic                 ramping;
  } level_report_t;

  // Tracks the ramp state from accepted commands and holds the reports the
  // block owes, oldest first.
  class ramp_tracker;
    logic signed [VW-1:0] level_now;
    logic signed [VW-1:0] level_goal;
    logic [CW-1:0]        samples_left;
    level_report_t        owed_reports[$];
    int                   failures;

    function new();
      level_now = '0;
      level_goal = '0;
      samples_left = '0;
      failures = 0;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    // Applies one accepted command and queues the report it must produce.
    function void take_command(logic [ACT_W-1:0] act, logic signed [VW-1:0] val,
                               logic [CW-1:0] cnt);
      longint             gap_to_goal;
      longint unsigned    gap_mag;
      longint unsigned    stride;
      level_report_t      rep;
      case (act)
        ACT_RESET: begin
          level_now = val;
          level_goal = val;
          samples_left = '0;
        end
        ACT_SET_GOAL: begin
          level_goal = val;
          if (cnt == 0) begin
            level_now = val;
            samples_left = '0;
          end else begin
            samples_left = cnt;
          end
        end
        ACT_ADVANCE: begin
          if (samples_left != 0) begin
            if (cnt >= samples_left) begin
              level_now = level_goal;
              samples_left = '0;
            end else begin
              // The step is the magnitude scaled down and then given back its
              // sign, which truncates toward zero.
              gap_to_goal = longint'(level_goal) - longint'(level_now);
              gap_mag = (gap_to_goal < 0) ? longint'(-gap_to_goal) : gap_to_goal;
              stride = gap_mag * cnt / samples_left;
              if (gap_to_goal < 0)
                level_now = level_now - stride[VW-1:0];
              else
                level_now = level_now + stride[VW-1:0];
              samples_left = samples_left - cnt;
            end
          end
        end
        default: ;
      endcase
      rep.current_level = level_now;
      rep.goal_level = level_goal;
      rep.ramping = (samples_left != 0);
      owed_reports.push_back(rep);
    endfunction

    // Compares one accepted result transaction with the oldest owed report.
    function void check_report(logic signed [VW-1:0] cur, logic signed [VW-1:0] goal,
                               logic ramp);
      level_report_t want;
      if (owed_reports.size() == 0) begin
        $error("unexpected result: current_level %0d goal_level %0d ramping %0b",
               cur, goal, ramp);
        failures++;
        return;
      end
      want = owed_reports.pop_front();
      if (cur !== want.current_level) begin
        $error("current_level: expected %0d, got %0d", want.current_level, cur);
        failures++;
      end
      if (goal !== want.goal_level) begin
        $error("goal_level: expected %0d, got %0d", want.goal_level, goal);
        failures++;
      end
      if (ramp !== want.ramping) begin
        $error("ramping: expected %0b, got %0b", want.ramping, ramp);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lpr_in_if  #(.VALUE_WIDTH(VW), .COUNT_WIDTH(CW)) in_ch ();
  lpr_out_if #(.VALUE_WIDTH(VW))                   out_ch ();

  linear_parameter_ramp #(
    .VALUE_WIDTH(VW),
    .COUNT_WIDTH(CW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ramp_tracker tracker = new();

  // Idle control shared by the two sides. A calm side never idles; hold_len asks
  // the result side for one long stretch with ready low.
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  int hold_len = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Offers one command transaction and returns once the block has taken it. Valid
  // stays high into the next command when no gap is chosen.
  task automatic push_command(input logic [ACT_W-1:0] act, input logic signed [VW-1:0] val,
                              input logic [CW-1:0] cnt);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.value <= val;
    in_ch.sample_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_command(act, val, cnt);
  endtask

  // Lowers valid and waits until every owed report has come back. At least one
  // edge passes, so valid is never lowered and raised in the same step.
  task automatic wait_for_reports();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Directed corner cases: extreme levels, the longest ramp, zero-length ramps,
  // zero consumed samples, an advance that lands exactly on the end, one that
  // overshoots, advances with no ramp pending, a new goal in the middle of a
  // ramp, a negative step that truncates toward zero, and the unused action code.
  task automatic run_corner_cases();
    push_command(ACT_ADVANCE, 32'sh0000_5555, 24'd5);
    push_command(ACT_REPORT_ONLY, 32'shAAAA_AAAA, 24'hAA_AAAA);
    push_command(ACT_RESET, LEVEL_MAX, SPAN_MAX);
    push_command(ACT_RESET, LEVEL_MIN, 24'd0);
    push_command(ACT_SET_GOAL, LEVEL_MAX, 24'd0);
    push_command(ACT_RESET, LEVEL_MIN, 24'd0);
    // Full-scale swing over the longest ramp the count allows.
    push_command(ACT_SET_GOAL, LEVEL_MAX, SPAN_MAX);
    push_command(ACT_ADVANCE, 32'sh0, 24'd1);
    push_command(ACT_ADVANCE, 32'sh0, 24'd0);
    push_command(ACT_ADVANCE, 32'sh0, 24'h7F_FFFF);
    push_command(ACT_REPORT_ONLY, LEVEL_MIN, 24'd3);
    push_command(ACT_ADVANCE, 32'sh0, SPAN_MAX);
    // Three single-sample steps down the whole range; the last one ends the ramp.
    push_command(ACT_RESET, LEVEL_MAX, 24'd0);
    push_command(ACT_SET_GOAL, LEVEL_MIN, 24'd3);
    push_command(ACT_ADVANCE, 32'sh0, 24'd1);
    push_command(ACT_ADVANCE, 32'sh0, 24'd1);
    push_command(ACT_ADVANCE, 32'sh0, 24'd1);
    push_command(ACT_ADVANCE, 32'sh0, 24'd2);
    // Halfway to -7 must give -3, not -4.
    push_command(ACT_RESET, 32'sh0, 24'd0);
    push_command(ACT_SET_GOAL, -32'sd7, 24'd2);
    push_command(ACT_ADVANCE, 32'sh0, 24'd1);
    push_command(ACT_SET_GOAL, 32'sd1000, 24'd9);
    push_command(ACT_ADVANCE, 32'sh0, 24'd4);
    push_command(ACT_SET_GOAL, -32'sd1, 24'd0);
    push_command(ACT_SET_GOAL, 32'sh0001_2345, 24'd7);
    push_command(ACT_ADVANCE, 32'sh0, 24'd10);
  endtask

  function automatic logic signed [VW-1:0] pick_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom;
    if (roll < 85) begin
      case ($urandom_range(0, 4))
        0: return LEVEL_MAX;
        1: return LEVEL_MIN;
        2: return '0;
        3: return -32'sd1;
        default: return $urandom_range(1, 255);
      endcase
    end
    // Near the current level, so small differences get exercised too.
    return tracker.level_now + $signed($urandom_range(0, 1 << 21)) - (32'sd1 <<< 20);
  endfunction

  // Ramp lengths: mostly short, some medium, a few anywhere in the count range, some zero.
  function automatic logic [CW-1:0] pick_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return CW'($urandom_range(1, 16));
    if (roll < 75) return CW'($urandom_range(17, 4096));
    if (roll < 90) return CW'($urandom);
    return '0;
  endfunction

  // Consumed samples relative to what is left: mostly a fraction of it, with
  // zero, an exact finish and an overshoot mixed in.
  function automatic logic [CW-1:0] pick_consumed(logic [CW-1:0] left);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 60) return CW'($urandom_range(1, int'(left) / 4 + 1));
    if (roll < 85) return CW'($urandom_range(1, int'(left)));
    return CW'($urandom_range(int'(left), int'(SPAN_MAX)));
  endfunction

  // Random part: mostly a new goal followed by a run of advances, with resets,
  // unused codes and advances on an idle ramp as noise. Only commands that change
  // or may change the state count toward the total.
  task automatic run_random_ramps(input int target);
    int        useful;
    int        steps;
    int        roll;
    bit        held;
    bit        drained;
    int        next_mood;
    logic [CW-1:0] left;
    useful = 0;
    held = 1'b0;
    drained = 1'b0;
    next_mood = 0;
    while (useful < target) begin
      // Every so often change how the two sides idle, including stretches
      // where neither idles at all.
      if (useful >= next_mood) begin
        sender_calm = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        next_mood = useful + $urandom_range(60, 200);
      end

      // Back-pressure: the result side holds off for a long stretch while a
      // burst of commands keeps coming, so the block fills and stops taking input.
      if (!held && useful >= target / 3) begin
        held = 1'b1;
        hold_len = HOLD_CYCLES;
        sender_calm = 1'b1;
        repeat (12) begin
          push_command(ACT_SET_GOAL, pick_level(), pick_span());
          push_command(ACT_ADVANCE, $urandom, pick_consumed(tracker.samples_left + CW'(1)));
          useful += 2;
        end
      end

      // Once, let the block run completely dry before going on.
      if (!drained && useful >= (2 * target) / 3) begin
        drained = 1'b1;
        wait_for_reports();
      end

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_command(ACT_RESET, pick_level(), CW'($urandom));
        useful++;
      end else if (roll < 14) begin
        case ($urandom_range(0, 2))
          0: push_command(ACT_REPORT_ONLY, $urandom, CW'($urandom));
          1: if (tracker.samples_left == 0) push_command(ACT_ADVANCE, $urandom, CW'($urandom));
          default: push_command(ACT_W'($urandom_range(0, 3)), $urandom, CW'($urandom));
        endcase
      end else begin
        push_command(ACT_SET_GOAL, pick_level(), pick_span());
        useful++;
        steps = $urandom_range(1, 8);
        while (steps > 0 && tracker.samples_left != 0) begin
          left = tracker.samples_left;
          push_command(ACT_ADVANCE, $urandom, pick_consumed(left));
          useful++;
          steps--;
        end
      end
    end
  endtask

  // Result side: checks every accepted result transaction and drives ready with
  // random stalls, a long hold-off on request, and calm stretches.
  initial begin : result_sink
    int stall;
    int hold_left;
    stall = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_report(out_ch.current_level, out_ch.goal_level, out_ch.ramping);
      if (hold_left == 0 && hold_len > 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall = receiver_calm ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Main sequence: reset once, the directed corners, the random ramps, then
  // drain and report.
  initial begin : stimulus
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_RESET;
    in_ch.value <= '0;
    in_ch.sample_count <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_corner_cases();
    run_random_ramps(RANDOM_ITEMS);

    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* linear_parameter_ramp.f */
+incdir+hw/rtl
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_ifs.sv
hw/rtl/lpr_mul.sv
hw/rtl/lpr_div.sv
hw/rtl/linear_parameter_ramp.sv
hw/rtl/lpr_chk.sv
tb/linear_parameter_ramp_tb.sv
